// ===== rtl/core/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the indexed list store: opcodes, sequencer
// states and the command word broadcast to the row of entry cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned DATA_W        = 32;

   typedef enum logic [2:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_REMOVE = 3'd2,
      OP_READ   = 3'd3,
      OP_FIND   = 3'd4,
      OP_SWAP   = 3'd5,
      OP_CLEAR  = 3'd6
   } ils_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EXEC
   } ils_state_type;

   // sample: cells latch their match flag; commit: cells take their next entry
   typedef struct packed {
      logic       sample;
      logic       commit;
      logic       ok;
      ils_op_type op;
   } ils_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/ils_cell.sv =====
// ----------------------------------------------------------------------------
// ils_cell
// One list slot: holds an entry, compares it against the search word and
// picks its next entry from its neighbors, the new word or a swap operand.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_cell #(
   parameter int unsigned DEPTH      = ils_pkg::DEPTH_DEFAULT,
   parameter int unsigned CELL_INDEX = 0,
   localparam int unsigned CntW      = $clog2(DEPTH + 1),
   localparam int unsigned IdxW      = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire ils_pkg::ils_cmd_type      cmd,
   input  wire logic [CntW-1:0]           pos,
   input  wire logic [IdxW-1:0]           pos2,
   input  wire logic [CntW-1:0]           count,
   input  wire logic [ils_pkg::DATA_W-1:0] value,
   input  wire logic [ils_pkg::DATA_W-1:0] swap_a,
   input  wire logic [ils_pkg::DATA_W-1:0] swap_b,
   input  wire logic [ils_pkg::DATA_W-1:0] left_entry,
   input  wire logic [ils_pkg::DATA_W-1:0] right_entry,
   output logic      [ils_pkg::DATA_W-1:0] entry,
   output logic                           match
);

   localparam logic [CntW-1:0] MyIdx = CntW'(CELL_INDEX);

   logic [ils_pkg::DATA_W-1:0] entry_ff, entry_in;
   logic                       match_ff, match_in;
   logic [CntW-1:0]            pos2_ext;

   assign pos2_ext = CntW'(pos2);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.commit && cmd.ok) begin
         case (cmd.op)
            ils_pkg::OP_APPEND: begin
               if (MyIdx == count) entry_in = value;
            end
            ils_pkg::OP_INSERT: begin
               if (MyIdx == pos) entry_in = value;
               else if (MyIdx > pos) entry_in = left_entry;
            end
            ils_pkg::OP_REMOVE: begin
               if (MyIdx >= pos) entry_in = right_entry;
            end
            ils_pkg::OP_SWAP: begin
               // swap_a is entry[pos], swap_b is entry[pos2]
               if (MyIdx == pos) entry_in = swap_b;
               else if (MyIdx == pos2_ext) entry_in = swap_a;
            end
            default: entry_in = entry_ff;
         endcase
      end
   end

   always_comb begin
      match_in = match_ff;
      if (cmd.sample) match_in = (entry_ff == value) && (MyIdx < count);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

// ===== rtl/core/indexed_list_store_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_unit
// Fixed-capacity ordered list of signed 32-bit words built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_* and raise start; the word is taken at a
//   rising edge with start high and busy low. busy stays high while the
//   command is worked on, through the LOAD and EXEC states.
//   Result channel: rsp_valid is high for exactly one cycle with all rsp_*
//   ports; the receiver must take it then, there is no back-pressure.
//   Timing: after acceptance the command reads the cells in LOAD (swap
//   operands, read word, per-cell match flags), commits in EXEC, and the
//   result is registered and on the ports once the sequencer is back in
//   IDLE; a new command may be accepted in that same cycle, but not before
//   the last one has finished. The match priority encode and the two
//   operand muxes across DEPTH cells set the per-cycle work.
//   Reset: clears the entry count, rsp_valid and the sequencer; entry
//   contents are not cleared and are never visible until written.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store_unit #(
   parameter int unsigned DEPTH = ils_pkg::DEPTH_DEFAULT,
   localparam int unsigned CntW = $clog2(DEPTH + 1),
   localparam int unsigned IdxW = $clog2(DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [2:0]                 req_type,
   input  wire logic [CntW-1:0]            req_position,
   input  wire logic [IdxW-1:0]            req_second_position,
   input  wire logic signed [ils_pkg::DATA_W-1:0] req_value,
   output logic                            rsp_valid,
   output logic                            rsp_ok,
   output logic signed [ils_pkg::DATA_W-1:0] rsp_read_value,
   output logic                            rsp_found,
   output logic [IdxW-1:0]                 rsp_found_position,
   output logic [CntW-1:0]                 rsp_entry_count,
   output logic                            rsp_is_empty
);

   localparam int unsigned DW = ils_pkg::DATA_W;

   ils_pkg::ils_state_type state_ff, state_in;
   ils_pkg::ils_op_type    op_ff, op_in;
   logic [CntW-1:0]        pos_ff, pos_in;
   logic [IdxW-1:0]        pos2_ff, pos2_in;
   logic [DW-1:0]          value_ff, value_in;
   logic [CntW-1:0]        count_ff, count_in;
   logic [DW-1:0]          rd_a_ff, rd_a_in;
   logic [DW-1:0]          rd_b_ff, rd_b_in;
   logic                   ok_ff, ok_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [DW-1:0]          rsp_rd_ff, rsp_rd_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [IdxW-1:0]        rsp_fpos_ff, rsp_fpos_in;
   logic [CntW-1:0]        rsp_count_ff, rsp_count_in;

   logic                   accept;
   logic                   do_load, do_exec;
   ils_pkg::ils_cmd_type   cmd;
   logic [DW-1:0]          entry_bus [DEPTH];
   logic [DEPTH-1:0]       match_vec;
   logic [IdxW-1:0]        hit_idx;
   logic                   ok_calc;
   logic [CntW-1:0]        pos2_ext;

   assign accept   = start && !busy;
   assign pos2_ext = CntW'(pos2_ff);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ils_pkg::ST_IDLE: if (accept) state_in = ils_pkg::ST_LOAD;
         ils_pkg::ST_LOAD: state_in = ils_pkg::ST_EXEC;
         ils_pkg::ST_EXEC: state_in = ils_pkg::ST_IDLE;
         default:          state_in = ils_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy    = 1'b1;
      do_load = 1'b0;
      do_exec = 1'b0;
      case (state_ff)
         ils_pkg::ST_IDLE: busy = 1'b0;
         ils_pkg::ST_LOAD: do_load = 1'b1;
         ils_pkg::ST_EXEC: do_exec = 1'b1;
         default:          busy = 1'b1;
      endcase
   end

   // ---------------- request capture ----------------
   always_comb begin
      op_in    = op_ff;
      pos_in   = pos_ff;
      pos2_in  = pos2_ff;
      value_in = value_ff;
      if (accept) begin
         op_in    = ils_pkg::ils_op_type'(req_type);
         pos_in   = req_position;
         pos2_in  = req_second_position;
         value_in = req_value;
      end
   end

   // ---------------- operand read and bounds check ----------------
   always_comb begin
      case (op_ff)
         ils_pkg::OP_APPEND: ok_calc = (count_ff < CntW'(DEPTH));
         ils_pkg::OP_INSERT: ok_calc = (count_ff < CntW'(DEPTH)) && (pos_ff <= count_ff);
         ils_pkg::OP_REMOVE: ok_calc = (pos_ff < count_ff);
         ils_pkg::OP_READ:   ok_calc = (pos_ff < count_ff);
         ils_pkg::OP_FIND:   ok_calc = 1'b1;
         ils_pkg::OP_SWAP:   ok_calc = (pos_ff < count_ff) && (pos2_ext < count_ff);
         ils_pkg::OP_CLEAR:  ok_calc = 1'b1;
         default:            ok_calc = 1'b0;
      endcase
   end

   always_comb begin
      ok_in   = ok_ff;
      rd_a_in = rd_a_ff;
      rd_b_in = rd_b_ff;
      if (do_load) begin
         ok_in = ok_calc;
         // out-of-range positions only alias here; ok gates every use
         rd_a_in = entry_bus[pos_ff[IdxW-1:0]];
         rd_b_in = entry_bus[pos2_ff];
      end
   end

   // ---------------- cell row ----------------
   always_comb begin
      cmd.sample = do_load;
      cmd.commit = do_exec;
      cmd.ok     = ok_ff;
      cmd.op     = op_ff;
   end

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DW-1:0] left_w, right_w;
      if (gi == 0) begin : g_first
         assign left_w = entry_bus[gi];
      end else begin : g_mid_l
         assign left_w = entry_bus[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
         assign right_w = entry_bus[gi];
      end else begin : g_mid_r
         assign right_w = entry_bus[gi+1];
      end

      ils_cell #(
         .DEPTH      (DEPTH),
         .CELL_INDEX (gi)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .pos         (pos_ff),
         .pos2        (pos2_ff),
         .count       (count_ff),
         .value       (value_ff),
         .swap_a      (rd_a_ff),
         .swap_b      (rd_b_ff),
         .left_entry  (left_w),
         .right_entry (right_w),
         .entry       (entry_bus[gi]),
         .match       (match_vec[gi])
      );
   end

   // lowest matching cell wins
   always_comb begin
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_vec[i]) hit_idx = IdxW'(i);
      end
   end

   // ---------------- commit and result ----------------
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = do_exec;
      rsp_ok_in    = rsp_ok_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_found_in = rsp_found_ff;
      rsp_fpos_in  = rsp_fpos_ff;
      rsp_count_in = rsp_count_ff;
      if (do_exec) begin
         if (ok_ff) begin
            case (op_ff)
               ils_pkg::OP_APPEND: count_in = count_ff + CntW'(1);
               ils_pkg::OP_INSERT: count_in = count_ff + CntW'(1);
               ils_pkg::OP_REMOVE: count_in = count_ff - CntW'(1);
               ils_pkg::OP_CLEAR:  count_in = '0;
               default:            count_in = count_ff;
            endcase
         end
         rsp_ok_in    = ok_ff;
         rsp_rd_in    = '0;
         if (op_ff == ils_pkg::OP_READ) rsp_rd_in = ok_ff ? rd_a_ff : '1;
         rsp_found_in = (op_ff == ils_pkg::OP_FIND) && (|match_vec);
         rsp_fpos_in  = rsp_found_in ? hit_idx : '0;
         rsp_count_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ils_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      pos2_ff      <= pos2_in;
      value_ff     <= value_in;
      ok_ff        <= ok_in;
      rd_a_ff      <= rd_a_in;
      rd_b_ff      <= rd_b_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_rd_ff    <= rsp_rd_in;
      rsp_found_ff <= rsp_found_in;
      rsp_fpos_ff  <= rsp_fpos_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_read_value     = rsp_rd_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_is_empty       = (rsp_count_ff == '0);

endmodule

`default_nettype wire
